### src/psst_pkg.sv
// shared types, constants and helpers for the paired sample statistics block
// no dependencies; used by psst_arith, psst_seq and the top level
`default_nettype none

package psst_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CORR_FRAC   = 14;
    localparam int CORR_SHIFT  = CORR_FRAC + FRAC_BITS;
    localparam int CORR_ONE    = 16384;
    localparam int CNT_W       = 11;
    localparam int SUM_W       = 27;
    localparam int SQ_W        = 41;
    localparam int XY_W        = 42;
    localparam int WORD_W      = 64;
    localparam int STEP_CNT_W  = 6;

    localparam logic [STEP_CNT_W-1:0] DIV_LAST  = 6'd63;
    localparam logic [STEP_CNT_W-1:0] SQRT_LAST = 6'd31;
    localparam logic [WORD_W-1:0] SQRT_FIRST_BIT = 64'h4000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic              start;
        arith_op_t         op;
        logic [WORD_W-1:0] opa;
        logic [WORD_W-1:0] opb;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } arith_rsp_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_ZERO_VAR,
        STAT_TOO_FEW,
        STAT_OVERFLOW
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_CHECK,
        S_PUSH
    } seq_state_t;

    typedef enum logic [4:0] {
        SP_XX,
        SP_YY,
        SP_XY,
        SP_NSXX,
        SP_SXSX,
        SP_NSYY,
        SP_SYSY,
        SP_NSXY,
        SP_SXSY,
        SP_DPOP,
        SP_DSEL,
        SP_MX,
        SP_MY,
        SP_VX,
        SP_VY,
        SP_CV,
        SP_SX,
        SP_SY,
        SP_VPX,
        SP_VPY,
        SP_SPX,
        SP_SPY,
        SP_CPOP,
        SP_DEN,
        SP_CORR
    } step_t;

    typedef struct packed {
        logic [23:0]      mean_x;
        logic [23:0]      mean_y;
        logic [38:0]      var_x;
        logic [38:0]      var_y;
        logic [39:0]      covariance;
        logic [23:0]      std_x;
        logic [23:0]      std_y;
        logic [15:0]      correlation;
        logic [CNT_W-1:0] pair_count;
        status_t          status;
    } result_t;

    function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
    endfunction

    function automatic logic [WORD_W-1:0] neg_if(input logic neg, input logic [WORD_W-1:0] v);
        return neg ? (WORD_W'(0) - v) : v;
    endfunction

endpackage

`default_nettype wire

### src/psst_arith.sv
// shared iterative unit: shift-add multiply, restoring divide, bitwise square root
// one 64-bit add/compare per cycle; uses psst_pkg
`default_nettype none

module psst_arith (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire psst_pkg::arith_req_t req,
    output psst_pkg::arith_rsp_t      rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    psst_pkg::arith_op_t                 op_reg, op_next;
    logic [psst_pkg::STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [psst_pkg::WORD_W-1:0]         x_reg, x_next;
    logic [psst_pkg::WORD_W-1:0]         y_reg, y_next;
    logic [psst_pkg::WORD_W-1:0]         acc_reg, acc_next;
    logic [psst_pkg::WORD_W-1:0]         rem_reg, rem_next;

    logic [psst_pkg::WORD_W:0]           div_sh;
    logic [psst_pkg::WORD_W-1:0]         trial;
    logic [psst_pkg::WORD_W:0]           sq_diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        div_sh    = {rem_reg, x_reg[psst_pkg::WORD_W-1]};
        trial     = acc_reg + x_reg;
        sq_diff   = {1'b0, rem_reg} - {1'b0, trial};
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            y_next    = req.opb;
            acc_next  = '0;
            rem_next  = '0;
            x_next    = req.opa;
            if (req.op == psst_pkg::OP_SQRT) begin
                rem_next = req.opa;
                x_next   = psst_pkg::SQRT_FIRST_BIT;
            end
        end else if (busy_reg) begin
            unique case (op_reg)
                psst_pkg::OP_MUL: begin
                    if (y_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        if (y_reg[0]) begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = {x_reg[psst_pkg::WORD_W-2:0], 1'b0};
                        y_next = {1'b0, y_reg[psst_pkg::WORD_W-1:1]};
                    end
                end
                psst_pkg::OP_DIV: begin
                    if (div_sh >= {1'b0, y_reg}) begin
                        rem_next = div_sh[psst_pkg::WORD_W-1:0] - y_reg;
                        x_next   = {x_reg[psst_pkg::WORD_W-2:0], 1'b1};
                    end else begin
                        rem_next = div_sh[psst_pkg::WORD_W-1:0];
                        x_next   = {x_reg[psst_pkg::WORD_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == psst_pkg::DIV_LAST) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                psst_pkg::OP_SQRT: begin
                    if (!sq_diff[psst_pkg::WORD_W]) begin
                        rem_next = sq_diff[psst_pkg::WORD_W-1:0];
                        acc_next = {1'b0, acc_reg[psst_pkg::WORD_W-1:1]} + x_reg;
                    end else begin
                        acc_next = {1'b0, acc_reg[psst_pkg::WORD_W-1:1]};
                    end
                    x_next   = {2'b00, x_reg[psst_pkg::WORD_W-1:2]};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == psst_pkg::SQRT_LAST) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= psst_pkg::OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        rsp.done = done_reg;
        case (op_reg)
            psst_pkg::OP_DIV: rsp.result = x_reg;
            default:          rsp.result = acc_reg;
        endcase
    end

endmodule

`default_nettype wire

### src/psst_seq.sv
// sequencer: accumulators, step order of the final statistics, result registers
// drives psst_arith through arith_req_t / arith_rsp_t from psst_pkg
`default_nettype none

module psst_seq (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [psst_pkg::SAMPLE_BITS-1:0] in_x,
    input  wire logic signed [psst_pkg::SAMPLE_BITS-1:0] in_y,
    input  wire logic                                    in_last,
    input  wire logic                                    mode,
    input  wire logic                                    out_free,
    output logic                                         out_push,
    output psst_pkg::result_t                            out_result,
    output psst_pkg::arith_req_t                         areq,
    input  wire psst_pkg::arith_rsp_t                    arsp
);

    localparam int W = psst_pkg::WORD_W;

    psst_pkg::seq_state_t state_reg, state_next;
    psst_pkg::step_t      step_reg, step_next;

    logic signed [psst_pkg::SAMPLE_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic                                    last_reg, last_next;
    logic [psst_pkg::CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [psst_pkg::SUM_W-1:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic [psst_pkg::SQ_W-1:0]               sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [psst_pkg::XY_W-1:0]        sxy_reg, sxy_next;
    logic                                    cap_reg, cap_next;
    logic                                    zvar_reg, zvar_next;
    logic [W-1:0] t1_reg, t1_next, dxx_reg, dxx_next, dyy_reg, dyy_next;
    logic [W-1:0] dxy_reg, dxy_next, dpop_reg, dpop_next, dsel_reg, dsel_next;
    logic [W-1:0] mx_reg, mx_next, my_reg, my_next, vx_reg, vx_next, vy_reg, vy_next;
    logic [W-1:0] cv_reg, cv_next, sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [W-1:0] vpx_reg, vpx_next, vpy_reg, vpy_next, spx_reg, spx_next;
    logic [W-1:0] spy_reg, spy_next, cpop_reg, cpop_next;
    logic [15:0]  corr_reg, corr_next;

    logic [W-1:0] n64, sx64, sy64, sxy64, xa, ya, res, qc;
    logic         full, few, xneg, yneg;

    assign n64   = W'(cnt_reg);
    assign sx64  = W'(sx_reg);
    assign sy64  = W'(sy_reg);
    assign sxy64 = W'(sxy_reg);
    assign xa    = psst_pkg::abs_word(W'(x_reg));
    assign ya    = psst_pkg::abs_word(W'(y_reg));
    assign xneg  = x_reg[psst_pkg::SAMPLE_BITS-1];
    assign yneg  = y_reg[psst_pkg::SAMPLE_BITS-1];
    assign res   = arsp.result;
    assign full  = cnt_reg >= psst_pkg::CNT_W'(psst_pkg::MAX_SAMPLES);
    assign few   = (cnt_reg == '0) || (mode && (cnt_reg < psst_pkg::CNT_W'(2)));
    assign qc    = (res > W'(psst_pkg::CORR_ONE)) ? W'(psst_pkg::CORR_ONE) : res;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psst_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = full ? psst_pkg::S_CHECK : psst_pkg::S_ISSUE;
                end
            end
            psst_pkg::S_ISSUE: state_next = psst_pkg::S_WAIT;
            psst_pkg::S_WAIT: begin
                if (arsp.done) begin
                    if (step_reg == psst_pkg::SP_XY) begin
                        state_next = psst_pkg::S_CHECK;
                    end else if (step_reg == psst_pkg::SP_CORR) begin
                        state_next = psst_pkg::S_PUSH;
                    end else if (step_reg == psst_pkg::SP_DEN && res == '0) begin
                        state_next = psst_pkg::S_PUSH;
                    end else begin
                        state_next = psst_pkg::S_ISSUE;
                    end
                end
            end
            psst_pkg::S_CHECK: begin
                if (!last_reg) begin
                    state_next = psst_pkg::S_IDLE;
                end else if (few) begin
                    state_next = psst_pkg::S_PUSH;
                end else begin
                    state_next = psst_pkg::S_ISSUE;
                end
            end
            psst_pkg::S_PUSH: begin
                if (out_free) begin
                    state_next = psst_pkg::S_IDLE;
                end
            end
            default: state_next = psst_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready = (state_reg == psst_pkg::S_IDLE);
        out_push = (state_reg == psst_pkg::S_PUSH) && out_free;
        areq.start = (state_reg == psst_pkg::S_ISSUE);
        areq.op  = psst_pkg::OP_MUL;
        areq.opa = '0;
        areq.opb = '0;
        unique case (step_reg)
            psst_pkg::SP_XX:   begin areq.opa = xa; areq.opb = xa; end
            psst_pkg::SP_YY:   begin areq.opa = ya; areq.opb = ya; end
            psst_pkg::SP_XY:   begin areq.opa = xa; areq.opb = ya; end
            psst_pkg::SP_NSXX: begin areq.opa = n64; areq.opb = W'(sxx_reg); end
            psst_pkg::SP_SXSX: begin
                areq.opa = psst_pkg::abs_word(sx64);
                areq.opb = psst_pkg::abs_word(sx64);
            end
            psst_pkg::SP_NSYY: begin areq.opa = n64; areq.opb = W'(syy_reg); end
            psst_pkg::SP_SYSY: begin
                areq.opa = psst_pkg::abs_word(sy64);
                areq.opb = psst_pkg::abs_word(sy64);
            end
            psst_pkg::SP_NSXY: begin areq.opa = n64; areq.opb = psst_pkg::abs_word(sxy64); end
            psst_pkg::SP_SXSY: begin
                areq.opa = psst_pkg::abs_word(sx64);
                areq.opb = psst_pkg::abs_word(sy64);
            end
            psst_pkg::SP_DPOP: begin areq.opa = n64; areq.opb = n64; end
            psst_pkg::SP_DSEL: begin
                areq.opa = n64;
                areq.opb = mode ? (n64 - W'(1)) : n64;
            end
            psst_pkg::SP_MX: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = psst_pkg::abs_word(sx64) << psst_pkg::FRAC_BITS;
                areq.opb = n64;
            end
            psst_pkg::SP_MY: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = psst_pkg::abs_word(sy64) << psst_pkg::FRAC_BITS;
                areq.opb = n64;
            end
            psst_pkg::SP_VX: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = dxx_reg << psst_pkg::FRAC_BITS;
                areq.opb = dsel_reg;
            end
            psst_pkg::SP_VY: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = dyy_reg << psst_pkg::FRAC_BITS;
                areq.opb = dsel_reg;
            end
            psst_pkg::SP_CV: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = psst_pkg::abs_word(dxy_reg) << psst_pkg::FRAC_BITS;
                areq.opb = dsel_reg;
            end
            psst_pkg::SP_SX: begin
                areq.op  = psst_pkg::OP_SQRT;
                areq.opa = vx_reg << psst_pkg::FRAC_BITS;
            end
            psst_pkg::SP_SY: begin
                areq.op  = psst_pkg::OP_SQRT;
                areq.opa = vy_reg << psst_pkg::FRAC_BITS;
            end
            psst_pkg::SP_VPX: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = dxx_reg << psst_pkg::FRAC_BITS;
                areq.opb = dpop_reg;
            end
            psst_pkg::SP_VPY: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = dyy_reg << psst_pkg::FRAC_BITS;
                areq.opb = dpop_reg;
            end
            psst_pkg::SP_SPX: begin
                areq.op  = psst_pkg::OP_SQRT;
                areq.opa = vpx_reg << psst_pkg::FRAC_BITS;
            end
            psst_pkg::SP_SPY: begin
                areq.op  = psst_pkg::OP_SQRT;
                areq.opa = vpy_reg << psst_pkg::FRAC_BITS;
            end
            psst_pkg::SP_CPOP: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = psst_pkg::abs_word(dxy_reg) << psst_pkg::FRAC_BITS;
                areq.opb = dpop_reg;
            end
            psst_pkg::SP_DEN: begin areq.opa = spx_reg; areq.opb = spy_reg; end
            psst_pkg::SP_CORR: begin
                areq.op  = psst_pkg::OP_DIV;
                areq.opa = cpop_reg << psst_pkg::CORR_SHIFT;
                areq.opb = t1_reg;
            end
            default: areq.op = psst_pkg::OP_MUL;
        endcase
    end

    // datapath
    always_comb begin
        step_next = step_reg;
        x_next = x_reg;  y_next = y_reg;  last_next = last_reg;
        cnt_next = cnt_reg;  sx_next = sx_reg;  sy_next = sy_reg;
        sxx_next = sxx_reg;  syy_next = syy_reg;  sxy_next = sxy_reg;
        cap_next = cap_reg;  zvar_next = zvar_reg;
        t1_next = t1_reg;  dxx_next = dxx_reg;  dyy_next = dyy_reg;  dxy_next = dxy_reg;
        dpop_next = dpop_reg;  dsel_next = dsel_reg;  mx_next = mx_reg;  my_next = my_reg;
        vx_next = vx_reg;  vy_next = vy_reg;  cv_next = cv_reg;
        sdx_next = sdx_reg;  sdy_next = sdy_reg;  vpx_next = vpx_reg;  vpy_next = vpy_reg;
        spx_next = spx_reg;  spy_next = spy_reg;  cpop_next = cpop_reg;  corr_next = corr_reg;

        if (state_reg == psst_pkg::S_IDLE && in_valid) begin
            x_next    = in_x;
            y_next    = in_y;
            last_next = in_last;
            step_next = psst_pkg::SP_XX;
            if (full) begin
                cap_next = 1'b1;
            end
        end
        if (state_reg == psst_pkg::S_CHECK) begin
            step_next = psst_pkg::SP_NSXX;
        end
        if (state_reg == psst_pkg::S_WAIT && arsp.done) begin
            step_next = psst_pkg::step_t'(step_reg + 1'b1);
            case (step_reg)
                psst_pkg::SP_XX: sxx_next = sxx_reg + res[psst_pkg::SQ_W-1:0];
                psst_pkg::SP_YY: syy_next = syy_reg + res[psst_pkg::SQ_W-1:0];
                psst_pkg::SP_XY: begin
                    sxy_next = sxy_reg + psst_pkg::XY_W'(psst_pkg::neg_if(xneg ^ yneg, res));
                    sx_next  = sx_reg + psst_pkg::SUM_W'(x_reg);
                    sy_next  = sy_reg + psst_pkg::SUM_W'(y_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
                psst_pkg::SP_NSXX: t1_next = res;
                psst_pkg::SP_SXSX: dxx_next = t1_reg - res;
                psst_pkg::SP_NSYY: t1_next = res;
                psst_pkg::SP_SYSY: dyy_next = t1_reg - res;
                psst_pkg::SP_NSXY: t1_next = psst_pkg::neg_if(sxy_reg[psst_pkg::XY_W-1], res);
                psst_pkg::SP_SXSY: begin
                    dxy_next = t1_reg - psst_pkg::neg_if(
                        sx_reg[psst_pkg::SUM_W-1] ^ sy_reg[psst_pkg::SUM_W-1], res);
                end
                psst_pkg::SP_DPOP: dpop_next = res;
                psst_pkg::SP_DSEL: dsel_next = res;
                psst_pkg::SP_MX: mx_next = psst_pkg::neg_if(sx_reg[psst_pkg::SUM_W-1], res);
                psst_pkg::SP_MY: my_next = psst_pkg::neg_if(sy_reg[psst_pkg::SUM_W-1], res);
                psst_pkg::SP_VX: vx_next = res;
                psst_pkg::SP_VY: vy_next = res;
                psst_pkg::SP_CV: cv_next = psst_pkg::neg_if(dxy_reg[W-1], res);
                psst_pkg::SP_SX: sdx_next = res;
                psst_pkg::SP_SY: sdy_next = res;
                psst_pkg::SP_VPX: vpx_next = res;
                psst_pkg::SP_VPY: vpy_next = res;
                psst_pkg::SP_SPX: spx_next = res;
                psst_pkg::SP_SPY: spy_next = res;
                psst_pkg::SP_CPOP: cpop_next = res;
                psst_pkg::SP_DEN: begin
                    t1_next = res;
                    if (res == '0) begin
                        zvar_next = 1'b1;
                        corr_next = '0;
                    end
                end
                psst_pkg::SP_CORR: corr_next = 16'(psst_pkg::neg_if(dxy_reg[W-1], qc));
                default: step_next = step_reg;
            endcase
        end
        if (out_push) begin
            cnt_next  = '0;
            sx_next   = '0;
            sy_next   = '0;
            sxx_next  = '0;
            syy_next  = '0;
            sxy_next  = '0;
            cap_next  = 1'b0;
            zvar_next = 1'b0;
        end
    end

    always_comb begin
        out_result.mean_x      = few ? '0 : mx_reg[23:0];
        out_result.mean_y      = few ? '0 : my_reg[23:0];
        out_result.var_x       = few ? '0 : vx_reg[38:0];
        out_result.var_y       = few ? '0 : vy_reg[38:0];
        out_result.covariance  = few ? '0 : cv_reg[39:0];
        out_result.std_x       = few ? '0 : sdx_reg[23:0];
        out_result.std_y       = few ? '0 : sdy_reg[23:0];
        out_result.correlation = few ? '0 : corr_reg;
        out_result.pair_count  = cnt_reg;
        if (few) begin
            out_result.status = psst_pkg::STAT_TOO_FEW;
        end else if (cap_reg) begin
            out_result.status = psst_pkg::STAT_OVERFLOW;
        end else if (zvar_reg) begin
            out_result.status = psst_pkg::STAT_ZERO_VAR;
        end else begin
            out_result.status = psst_pkg::STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psst_pkg::S_IDLE;
            step_reg  <= psst_pkg::SP_XX;
            last_reg  <= 1'b0;
            cnt_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            cap_reg   <= 1'b0;
            zvar_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            sxy_reg   <= sxy_next;
            cap_reg   <= cap_next;
            zvar_reg  <= zvar_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        t1_reg   <= t1_next;
        dxx_reg  <= dxx_next;
        dyy_reg  <= dyy_next;
        dxy_reg  <= dxy_next;
        dpop_reg <= dpop_next;
        dsel_reg <= dsel_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        cv_reg   <= cv_next;
        sdx_reg  <= sdx_next;
        sdy_reg  <= sdy_next;
        vpx_reg  <= vpx_next;
        vpy_reg  <= vpy_next;
        spx_reg  <= spx_next;
        spy_reg  <= spy_next;
        cpop_reg <= cpop_next;
        corr_reg <= corr_next;
    end

endmodule

`default_nettype wire

### src/paired_sample_statistics_top.sv
// paired sample statistics: stream ports, mode register and result output register
// depends on psst_pkg, psst_seq and psst_arith
//
// usage:
//   s_ channel: one (x, y) pair per beat, s_tlast marks the last pair of a set.
//   m_ channel: one result beat per set, sent after the last pair.
//   cfg channel: writes sample_mode (0 population, 1 sample); write only when idle.
// operations:
//   every pair goes through the shared multiply/divide/sqrt unit three times.
//   after the last pair, the closing statistics take nine 64-step divides,
//   four 32-step roots and the multiplies in that unit.
//   pairs past 1024 in a set are dropped and flag overflow.
// reset: synchronous, active low; clears the sums, count and mode.
// stall: the finished result waits in the output register; the next set can
//   accumulate meanwhile, and only a second result waits for m_tready.
`default_nettype none

module paired_sample_statistics_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // x_sample[15:0], y_sample[31:16]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [247:0]      m_tdata,   // mean_x, mean_y, var_x, var_y, covariance,
                                         // std_x, std_y, correlation, pair_count, zero pad
    output logic [1:0]        m_tuser,   // status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_data   // sample_mode
);

    logic                 mode_reg, mode_next;
    logic                 mvalid_reg, mvalid_next;
    psst_pkg::result_t    out_reg, out_next;
    psst_pkg::result_t    seq_result;
    psst_pkg::arith_req_t areq;
    psst_pkg::arith_rsp_t arsp;
    logic                 out_free, push;

    assign cfg_ready = 1'b1;
    assign out_free  = !mvalid_reg || m_tready;

    always_comb begin
        mode_next   = mode_reg;
        mvalid_next = mvalid_reg;
        out_next    = out_reg;
        if (cfg_valid) begin
            mode_next = cfg_data[0];
        end
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        if (push) begin
            mvalid_next = 1'b1;
            out_next    = seq_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            mvalid_reg <= mvalid_next;
        end
        out_reg <= out_next;
    end

    psst_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_x       (s_tdata[15:0]),
        .in_y       (s_tdata[31:16]),
        .in_last    (s_tlast),
        .mode       (mode_reg),
        .out_free   (out_free),
        .out_push   (push),
        .out_result (seq_result),
        .areq       (areq),
        .arsp       (arsp)
    );

    psst_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .rsp     (arsp)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, out_reg.pair_count, out_reg.correlation, out_reg.std_y,
                       out_reg.std_x, out_reg.covariance, out_reg.var_y, out_reg.var_x,
                       out_reg.mean_y, out_reg.mean_x};
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// self-checking bench for paired_sample_statistics_top: streams (x, y) sets with random idling
// predicts every result beat from its own model of the sums; needs psst_pkg and the rtl
module tb;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } pair_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [247:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [0:0]   cfg_data = '0;

    pair_t             pair_queue[$];
    psst_pkg::result_t stats_queue[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;
    int      errors = 0;
    int      pairs_sent = 0;
    int      sets_checked = 0;
    int      status_seen[4] = '{0, 0, 0, 0};

    // predictor state
    logic        mode_q = 0;
    logic [63:0] acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    logic        acc_over;

    always #5 aclk = ~aclk;

    paired_sample_statistics_top uut (.*);

    function automatic logic [63:0] sdiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        mag = num[63] ? -num : num;
        if (den == 0) return 0;
        q = mag / den;
        return num[63] ? -q : q;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void clear_sums();
        acc_n = 0; acc_x = 0; acc_y = 0;
        acc_xx = 0; acc_yy = 0; acc_xy = 0;
        acc_over = 0;
    endfunction

    // accumulate one pair; on the last pair push the expected statistics
    function automatic void accumulate_pair(input pair_t p);
        logic [63:0] x, y, n, dxx, dyy, dxy, dpop, dsel;
        logic [63:0] vx, vy, vpx, vpy, spx, spy, cpop, den, mag, q;
        psst_pkg::result_t r;
        x = {{48{p.x[15]}}, p.x};
        y = {{48{p.y[15]}}, p.y};
        if (acc_n < psst_pkg::MAX_SAMPLES) begin
            acc_n++;
            acc_x += x; acc_y += y;
            acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
        end else begin
            acc_over = 1;
        end
        if (!p.last) return;
        r = '0;
        n = acc_n;
        if (n == 0 || (mode_q && n < 2)) begin
            r.status = psst_pkg::STAT_TOO_FEW;
        end else begin
            dxx = n * acc_xx - acc_x * acc_x;
            dyy = n * acc_yy - acc_y * acc_y;
            dxy = n * acc_xy - acc_x * acc_y;
            dpop = n * n;
            dsel = mode_q ? n * (n - 1) : dpop;
            r.mean_x = 24'(sdiv64(acc_x << 8, n));
            r.mean_y = 24'(sdiv64(acc_y << 8, n));
            vx = (dxx << 8) / dsel;
            vy = (dyy << 8) / dsel;
            r.var_x = 39'(vx);
            r.var_y = 39'(vy);
            r.covariance = 40'(sdiv64(dxy << 8, dsel));
            r.std_x = 24'(floor_sqrt(vx << 8));
            r.std_y = 24'(floor_sqrt(vy << 8));
            vpx = (dxx << 8) / dpop;
            vpy = (dyy << 8) / dpop;
            spx = floor_sqrt(vpx << 8);
            spy = floor_sqrt(vpy << 8);
            cpop = sdiv64(dxy << 8, dpop);
            den = spx * spy;
            r.status = psst_pkg::STAT_OK;
            if (den == 0) begin
                r.status = psst_pkg::STAT_ZERO_VAR;
            end else begin
                mag = cpop[63] ? -cpop : cpop;
                q = (mag << 22) / den;
                if (q > psst_pkg::CORR_ONE) q = psst_pkg::CORR_ONE;
                r.correlation = 16'(cpop[63] ? -q : q);
            end
            if (acc_over) r.status = psst_pkg::STAT_OVERFLOW;
        end
        r.pair_count = psst_pkg::CNT_W'(n);
        stats_queue.push_back(r);
        clear_sums();
    endfunction

    // input driver
    always @(posedge aclk) begin
        logic  fire;
        logic  nxt_valid;
        pair_t p;
        nxt_valid = 0;
        if (!aresetn) begin
            clear_sums();
            s_tvalid <= 0;
        end else if (s_tvalid && !s_tready) begin
            nxt_valid = 1;
            s_tvalid <= 1;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire) begin
                accumulate_pair(pair_queue.pop_front());
                pairs_sent++;
            end
            if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                p = pair_queue[0];
                s_tdata <= {p.y, p.x};
                s_tlast <= p.last;
                nxt_valid = 1;
            end
            s_tvalid <= nxt_valid;
        end
    end

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t: mismatch %s expected %0h actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        psst_pkg::result_t e;
        psst_pkg::result_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a = '0;
            a.mean_x = m_tdata[23:0];
            a.mean_y = m_tdata[47:24];
            a.var_x = m_tdata[86:48];
            a.var_y = m_tdata[125:87];
            a.covariance = m_tdata[165:126];
            a.std_x = m_tdata[189:166];
            a.std_y = m_tdata[213:190];
            a.correlation = m_tdata[229:214];
            a.pair_count = m_tdata[240:230];
            a.status = psst_pkg::status_t'(m_tuser);
            if (stats_queue.size() == 0) begin
                $display("%0t: mismatch unexpected beat, expected none actual %0h",
                         $time, m_tdata);
                errors++;
            end else begin
                e = stats_queue.pop_front();
                check_field("mean_x", e.mean_x, a.mean_x);
                check_field("mean_y", e.mean_y, a.mean_y);
                check_field("var_x", e.var_x, a.var_x);
                check_field("var_y", e.var_y, a.var_y);
                check_field("covariance", e.covariance, a.covariance);
                check_field("std_x", e.std_x, a.std_x);
                check_field("std_y", e.std_y, a.std_y);
                check_field("correlation", e.correlation, a.correlation);
                check_field("pair_count", e.pair_count, a.pair_count);
                check_field("status", e.status, a.status);
                status_seen[e.status]++;
                sets_checked++;
            end
        end
    end

    // receiver ready, with a counted long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_pair(input int x, input int y, input bit last);
        pair_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.last = last;
        pair_queue.push_back(p);
    endtask

    task automatic write_mode(input logic m);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= m;
        do @(posedge aclk); while (!cfg_ready);
        mode_q = m;
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (pair_queue.size() > 0 || s_tvalid || stats_queue.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic add_random_sets(input int pairs);
        int len;
        int lim;
        while (pairs > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            lim = $urandom_range(3);
            for (int i = 0; i < len; i++) begin
                if (lim == 0)
                    add_pair($urandom_range(7) - 4, $urandom_range(7) - 4, i == len - 1);
                else if (lim == 1)
                    add_pair($urandom_range(255) - 128, $urandom_range(255) - 128, i == len - 1);
                else
                    add_pair($urandom(), $urandom(), i == len - 1);
            end
            pairs -= len;
        end
    endtask

    initial begin
        int r;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, single pair, constant series, perfect correlation
        write_mode(0);
        add_pair(32767, 32767, 0);
        add_pair(-32768, -32768, 1);
        add_pair(-32768, 32767, 0);
        add_pair(32767, -32768, 1);
        add_pair(5, -7, 1);
        add_pair(100, 3, 0);
        add_pair(100, -9, 0);
        add_pair(100, 44, 1);
        add_pair(1, 2, 0);
        add_pair(2, 4, 0);
        add_pair(3, 6, 1);
        add_pair(10, -10, 0);
        add_pair(-20, 20, 1);
        wait_idle();
        write_mode(1);
        add_pair(1234, -4321, 1);
        add_pair(-32768, 32767, 0);
        add_pair(-32768, -32768, 0);
        add_pair(32767, 0, 1);
        add_pair(7, 7, 0);
        add_pair(7, 7, 1);
        wait_idle();

        // random phases with different idling, mode changes between them
        for (int ph = 0; ph < 4; ph++) begin
            write_mode(ph[0]);
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 50) : 0;
            recv_stall_pct = (ph == 2) ? 50 : ((ph == 3) ? 30 : 0);
            if (ph == 2) begin
                // short sets under a long hold so that results back up into the input
                hold_cycles = 4000;
                add_pair(3, 4, 1);
                add_pair(-3, 8, 1);
                add_pair(9, 1, 1);
                add_pair(-6, 2, 1);
            end
            add_random_sets(12);
            wait_idle();
        end

        // capacity set: pairs past the limit are dropped
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_mode(0);
        for (int i = 0; i < psst_pkg::MAX_SAMPLES + 3; i++) begin
            r = $urandom();
            add_pair(r, r >> 16, i == psst_pkg::MAX_SAMPLES + 2);
        end
        add_pair(-5, 9, 0);
        add_pair(4, 9, 1);
        wait_idle();
        write_mode(1);
        add_random_sets(20);
        wait_idle();
        repeat (1000) @(posedge aclk);

        $display("covered %0d pairs in %0d sets, both modes, idling and a long output hold",
                 pairs_sent, sets_checked);
        $display("status seen: ok %0d, zero variance %0d, too few %0d, overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && stats_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end
endmodule
